// File: design/cts_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Cloud temperature stencil cell package
// Widths, register indexes, reset values and arithmetic constants shared by
// the stencil cell pipeline and its fixed-point multiplier unit.
// ----------------------------------------------------------------------------
package cts_pkg;

   // Field and register widths
   localparam int DATA_W     = 32;
   localparam int TS_W       = 31;
   localparam int COND_W     = 31;
   localparam int INVL_W     = 11;
   localparam int CSR_DATA_W = 31;
   localparam int CSR_IDX_W  = 2;

   // Register indexes on the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_TIME_STEP    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CONDUCTIVITY = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_CELL_LEN = 2'd2;

   // Register reset values
   localparam logic [TS_W-1:0]   TS_RESET   = 31'd655;
   localparam logic [COND_W-1:0] COND_RESET = 31'd1593;
   localparam logic [INVL_W-1:0] INVL_RESET = 11'd10;

   // Internal arithmetic widths
   localparam int FRAC_W  = 16;
   localparam int DIFF_W  = 33;
   localparam int SUM_W   = 35;
   localparam int CNT_W   = 3;
   localparam int WMAG_W  = 32;
   localparam int PD_W    = DIFF_W + INVL_W;
   localparam int CAP_W   = 47;
   localparam int TMAG_W  = CAP_W + 1;
   localparam int TOTAL_W = 50;

   // Products are clamped to the intermediate magnitude limit
   localparam logic [CAP_W-1:0] ICAP = {CAP_W{1'b1}};

   // Division by three: floor(y / 3) = (y * DIV3_M) >> DIV3_SHIFT for y < 2^20
   localparam int DIV3_M_W   = 21;
   localparam int DIV3_SHIFT = 22;
   localparam logic [DIV3_M_W-1:0] DIV3_M = 21'h155556;
   localparam int DIV3_HI_W  = SUM_W - 18;
   localparam int DIV3_LO_W  = 18;
   localparam int DIV3_Q_W   = 16;

   // Number of register stages, the result register included
   localparam int N_STAGES = 9;

   // Load enables of the two register stages of a multiplier unit
   typedef struct packed {
      logic prod;
      logic cap;
   } mulq_ld_type;

endpackage
`default_nettype wire

// File: design/cloud_temperature_stencil_cell_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Cloud temperature stencil cell
// Next temperature of one grid cell from its value, four neighbours and the
// local wind, in signed Q16.16 with saturation.
// ----------------------------------------------------------------------------
// The block takes one request per clock when the result side does not stall.
// Nine register stages carry each request: the neighbour differences, their
// magnitudes, a two-step division of the conduction sum by the neighbour
// count, and two chained fixed-point multiplications on each of the conduction
// and advection paths, each split into a product stage and a clamp stage. A
// stall on the result side holds only the stages that are occupied, so empty
// stages keep filling; requests are refused only when every stage holds a
// request. There is no start-up delay after reset. Configuration must be written
// only while no request is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module cloud_temperature_stencil_cell_top (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic signed [cts_pkg::DATA_W-1:0]  req_center_value,
   input  wire logic signed [cts_pkg::DATA_W-1:0]  req_north_value,
   input  wire logic signed [cts_pkg::DATA_W-1:0]  req_west_value,
   input  wire logic signed [cts_pkg::DATA_W-1:0]  req_east_value,
   input  wire logic signed [cts_pkg::DATA_W-1:0]  req_south_value,
   input  wire logic signed [cts_pkg::DATA_W-1:0]  req_wind_x_speed,
   input  wire logic signed [cts_pkg::DATA_W-1:0]  req_wind_y_speed,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic signed [cts_pkg::DATA_W-1:0]       rsp_new_value,
   input  wire logic                               csr_wr_en,
   input  wire logic [cts_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [cts_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int NS = cts_pkg::N_STAGES;

   // Configuration registers
   logic [cts_pkg::TS_W-1:0]   ts_ff;
   logic [cts_pkg::COND_W-1:0] cond_ff;
   logic [cts_pkg::INVL_W-1:0] invl_ff;

   // Stage valid bits and load enables
   logic [NS:1] v_ff;
   logic [NS:1] ld;

   // Stage 1
   logic signed [cts_pkg::DIFF_W-1:0] diff_n, diff_w, diff_e, diff_s;
   logic [3:0]                        present;
   logic signed [cts_pkg::SUM_W-1:0]  sum_in;
   logic [cts_pkg::CNT_W-1:0]         cnt_in;
   logic                              wx_pos, wy_pos;
   logic [cts_pkg::WMAG_W-1:0]        wxm_in, wym_in;

   logic signed [cts_pkg::DATA_W-1:0] s1_center_ff;
   logic signed [cts_pkg::SUM_W-1:0]  s1_sum_ff;
   logic [cts_pkg::CNT_W-1:0]         s1_cnt_ff;
   logic signed [cts_pkg::DIFF_W-1:0] s1_dx_ff, s1_dy_ff;
   logic [cts_pkg::WMAG_W-1:0]        s1_wxm_ff, s1_wym_ff;
   logic                              s1_all4_ff;

   // Stage 2
   logic signed [cts_pkg::DATA_W-1:0] s2_center_ff;
   logic [cts_pkg::SUM_W-1:0]         s2_mag_ff;
   logic                              s2_cneg_ff;
   logic [cts_pkg::CNT_W-1:0]         s2_cnt_ff;
   logic [cts_pkg::DIFF_W-1:0]        s2_dxm_ff, s2_dym_ff;
   logic                              s2_dxpos_ff, s2_dypos_ff;
   logic [cts_pkg::WMAG_W-1:0]        s2_wxm_ff, s2_wym_ff;
   logic                              s2_all4_ff;

   // Stage 3
   logic [cts_pkg::DIV3_HI_W+cts_pkg::DIV3_M_W-1:0] qh_prod;
   logic signed [cts_pkg::DATA_W-1:0] s3_center_ff;
   logic [cts_pkg::SUM_W-1:0]         s3_mag_ff;
   logic [cts_pkg::DIV3_Q_W-1:0]      s3_qh_ff;
   logic                              s3_cneg_ff;
   logic [cts_pkg::CNT_W-1:0]         s3_cnt_ff;
   logic [cts_pkg::PD_W-1:0]          s3_pdx_ff, s3_pdy_ff;
   logic                              s3_dxpos_ff, s3_dypos_ff;
   logic [cts_pkg::WMAG_W-1:0]        s3_wxm_ff, s3_wym_ff;
   logic                              s3_all4_ff;

   // Stage 4
   logic [cts_pkg::DIV3_HI_W-1:0]     rh_full;
   logic [cts_pkg::DIV3_LO_W+1:0]     div_y;
   logic [cts_pkg::DIV3_LO_W+2+cts_pkg::DIV3_M_W-1:0] ql_prod;
   logic [cts_pkg::SUM_W-1:0]         avg3, avg_in;
   logic signed [cts_pkg::DATA_W-1:0] s4_center_ff;
   logic [cts_pkg::SUM_W-1:0]         s4_avg_ff;
   logic                              s4_cneg_ff;
   logic                              s4_dxpos_ff, s4_dypos_ff;
   logic                              s4_all4_ff;

   // Stage 5
   logic signed [cts_pkg::DATA_W-1:0] s5_center_ff;
   logic                              s5_cneg_ff;
   logic                              s5_dxpos_ff, s5_dypos_ff;
   logic                              s5_all4_ff;
   logic [cts_pkg::CAP_W-1:0]         advx_m, advy_m;

   // Stage 6
   logic [cts_pkg::TMAG_W-1:0]        tmag_in;
   logic                              tneg_in;
   logic signed [cts_pkg::DATA_W-1:0] s6_center_ff;
   logic                              s6_cneg_ff;
   logic                              s6_all4_ff;
   logic [cts_pkg::TMAG_W-1:0]        s6_tmag_ff;
   logic                              s6_tneg_ff;
   logic [cts_pkg::CAP_W-1:0]         cond1_m;

   // Stages 7 and 8
   logic signed [cts_pkg::DATA_W-1:0] s7_center_ff, s8_center_ff;
   logic                              s7_cneg_ff, s8_cneg_ff;
   logic                              s7_all4_ff, s8_all4_ff;
   logic                              s7_tneg_ff, s8_tneg_ff;
   logic [cts_pkg::CAP_W-1:0]         cond2_m, advt_m;

   // Result stage
   logic signed [cts_pkg::TMAG_W-1:0]  cond_s, adv_s;
   logic signed [cts_pkg::TOTAL_W-1:0] total;
   logic signed [cts_pkg::DATA_W-1:0]  rsp_new_value_ff, rsp_new_value_in;

   // ------------------------------------------------------------------------
   // Configuration
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         ts_ff   <= cts_pkg::TS_RESET;
         cond_ff <= cts_pkg::COND_RESET;
         invl_ff <= cts_pkg::INVL_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            cts_pkg::CSR_TIME_STEP: begin
               ts_ff <= csr_wdata;
            end
            cts_pkg::CSR_CONDUCTIVITY: begin
               cond_ff <= csr_wdata;
            end
            cts_pkg::CSR_INV_CELL_LEN: begin
               invl_ff <= csr_wdata[cts_pkg::INVL_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // Pipeline flow control: a stage loads when it is empty or moves on
   // ------------------------------------------------------------------------
   always_comb begin
      ld[NS] = !v_ff[NS] || !rsp_stall;
      for (int k = NS - 1; k >= 1; k--) begin
         ld[k] = !v_ff[k] || ld[k+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (ld[1]) begin
            v_ff[1] <= req_valid;
         end
         for (int k = 2; k <= NS; k++) begin
            if (ld[k]) begin
               v_ff[k] <= v_ff[k-1];
            end
         end
      end
   end

   assign req_stall = !ld[1];
   assign rsp_valid = v_ff[NS];

   // ------------------------------------------------------------------------
   // Stage 1: differences to the neighbours, conduction sum, upwind choice
   // ------------------------------------------------------------------------
   always_comb begin
      diff_n = {req_center_value[31], req_center_value}
             - {req_north_value[31], req_north_value};
      diff_w = {req_center_value[31], req_center_value}
             - {req_west_value[31], req_west_value};
      diff_e = {req_center_value[31], req_center_value}
             - {req_east_value[31], req_east_value};
      diff_s = {req_center_value[31], req_center_value}
             - {req_south_value[31], req_south_value};
      present = {|req_south_value, |req_east_value, |req_west_value,
                 |req_north_value};
      sum_in = (present[0] ? cts_pkg::SUM_W'(diff_n) : '0)
             + (present[1] ? cts_pkg::SUM_W'(diff_w) : '0)
             + (present[2] ? cts_pkg::SUM_W'(diff_e) : '0)
             + (present[3] ? cts_pkg::SUM_W'(diff_s) : '0);
      cnt_in = cts_pkg::CNT_W'(present[0]) + cts_pkg::CNT_W'(present[1])
             + cts_pkg::CNT_W'(present[2]) + cts_pkg::CNT_W'(present[3]);
      wx_pos = !req_wind_x_speed[31] && (|req_wind_x_speed);
      wy_pos = !req_wind_y_speed[31] && (|req_wind_y_speed);
      // The most negative speed negates to 2^31, which still fits unsigned.
      wxm_in = req_wind_x_speed[31] ? (~req_wind_x_speed + 32'd1) : req_wind_x_speed;
      wym_in = req_wind_y_speed[31] ? (~req_wind_y_speed + 32'd1) : req_wind_y_speed;
   end

   always_ff @(posedge clock) begin
      if (ld[1]) begin
         s1_center_ff <= req_center_value;
         s1_sum_ff    <= sum_in;
         s1_cnt_ff    <= cnt_in;
         s1_dx_ff     <= wx_pos ? diff_n : diff_s;
         s1_dy_ff     <= wy_pos ? diff_w : diff_e;
         s1_wxm_ff    <= wxm_in;
         s1_wym_ff    <= wym_in;
         s1_all4_ff   <= &present;
      end
   end

   // ------------------------------------------------------------------------
   // Stage 2: magnitudes and signs
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (ld[2]) begin
         s2_center_ff <= s1_center_ff;
         s2_mag_ff    <= s1_sum_ff[cts_pkg::SUM_W-1] ? -s1_sum_ff : s1_sum_ff;
         s2_cneg_ff   <= !s1_sum_ff[cts_pkg::SUM_W-1] && (|s1_sum_ff);
         s2_cnt_ff    <= s1_cnt_ff;
         s2_dxm_ff    <= s1_dx_ff[cts_pkg::DIFF_W-1] ? -s1_dx_ff : s1_dx_ff;
         s2_dym_ff    <= s1_dy_ff[cts_pkg::DIFF_W-1] ? -s1_dy_ff : s1_dy_ff;
         s2_dxpos_ff  <= !s1_dx_ff[cts_pkg::DIFF_W-1] && (|s1_dx_ff);
         s2_dypos_ff  <= !s1_dy_ff[cts_pkg::DIFF_W-1] && (|s1_dy_ff);
         s2_wxm_ff    <= s1_wxm_ff;
         s2_wym_ff    <= s1_wym_ff;
         s2_all4_ff   <= s1_all4_ff;
      end
   end

   // ------------------------------------------------------------------------
   // Stage 3: upper digit of the division by three, difference times 1/L
   // ------------------------------------------------------------------------
   assign qh_prod = {{cts_pkg::DIV3_M_W{1'b0}}, s2_mag_ff[cts_pkg::SUM_W-1:cts_pkg::DIV3_LO_W]}
                  * {{cts_pkg::DIV3_HI_W{1'b0}}, cts_pkg::DIV3_M};

   always_ff @(posedge clock) begin
      if (ld[3]) begin
         s3_center_ff <= s2_center_ff;
         s3_mag_ff    <= s2_mag_ff;
         s3_qh_ff     <= qh_prod[cts_pkg::DIV3_SHIFT+cts_pkg::DIV3_Q_W-1:cts_pkg::DIV3_SHIFT];
         s3_cneg_ff   <= s2_cneg_ff;
         s3_cnt_ff    <= s2_cnt_ff;
         s3_pdx_ff    <= {{cts_pkg::INVL_W{1'b0}}, s2_dxm_ff}
                       * {{cts_pkg::DIFF_W{1'b0}}, invl_ff};
         s3_pdy_ff    <= {{cts_pkg::INVL_W{1'b0}}, s2_dym_ff}
                       * {{cts_pkg::DIFF_W{1'b0}}, invl_ff};
         s3_dxpos_ff  <= s2_dxpos_ff;
         s3_dypos_ff  <= s2_dypos_ff;
         s3_wxm_ff    <= s2_wxm_ff;
         s3_wym_ff    <= s2_wym_ff;
         s3_all4_ff   <= s2_all4_ff;
      end
   end

   // ------------------------------------------------------------------------
   // Stage 4: lower digit of the division and choice of the average
   // ------------------------------------------------------------------------
   always_comb begin
      rh_full = s3_mag_ff[cts_pkg::SUM_W-1:cts_pkg::DIV3_LO_W]
              - {s3_qh_ff, 1'b0} - {1'b0, s3_qh_ff};
      // The remainder of the upper digit is below three and takes two bits.
      div_y   = {rh_full[1:0], s3_mag_ff[cts_pkg::DIV3_LO_W-1:0]};
      ql_prod = {{cts_pkg::DIV3_M_W{1'b0}}, div_y}
              * {{(cts_pkg::DIV3_LO_W+2){1'b0}}, cts_pkg::DIV3_M};
      avg3    = {1'b0, s3_qh_ff,
                 ql_prod[cts_pkg::DIV3_SHIFT+cts_pkg::DIV3_LO_W-1:cts_pkg::DIV3_SHIFT]};
      case (s3_cnt_ff)
         3'd2:    avg_in = s3_mag_ff >> 1;
         3'd3:    avg_in = avg3;
         3'd4:    avg_in = s3_mag_ff >> 2;
         default: avg_in = s3_mag_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (ld[4]) begin
         s4_center_ff <= s3_center_ff;
         s4_avg_ff    <= avg_in;
         s4_cneg_ff   <= s3_cneg_ff;
         s4_dxpos_ff  <= s3_dxpos_ff;
         s4_dypos_ff  <= s3_dypos_ff;
         s4_all4_ff   <= s3_all4_ff;
      end
   end

   // Advection terms |w| * |d| / L: products at stage 4, clamped at stage 5
   cts_mulq #(
      .MAG_W (cts_pkg::PD_W),
      .F_W   (cts_pkg::WMAG_W)
   ) u_mulq_advx (
      .clock (clock),
      .ld    ('{prod: ld[4], cap: ld[5]}),
      .mag   (s3_pdx_ff),
      .fac   (s3_wxm_ff),
      .res   (advx_m)
   );

   cts_mulq #(
      .MAG_W (cts_pkg::PD_W),
      .F_W   (cts_pkg::WMAG_W)
   ) u_mulq_advy (
      .clock (clock),
      .ld    ('{prod: ld[4], cap: ld[5]}),
      .mag   (s3_pdy_ff),
      .fac   (s3_wym_ff),
      .res   (advy_m)
   );

   // Conduction average times conductivity: products at stage 5, clamp at 6
   cts_mulq #(
      .MAG_W (cts_pkg::SUM_W),
      .F_W   (cts_pkg::COND_W)
   ) u_mulq_cond1 (
      .clock (clock),
      .ld    ('{prod: ld[5], cap: ld[6]}),
      .mag   (s4_avg_ff),
      .fac   (cond_ff),
      .res   (cond1_m)
   );

   always_ff @(posedge clock) begin
      if (ld[5]) begin
         s5_center_ff <= s4_center_ff;
         s5_cneg_ff   <= s4_cneg_ff;
         s5_dxpos_ff  <= s4_dxpos_ff;
         s5_dypos_ff  <= s4_dypos_ff;
         s5_all4_ff   <= s4_all4_ff;
      end
   end

   // ------------------------------------------------------------------------
   // Stage 6: signed sum of the two advection terms as sign and magnitude.
   // A term is negative when its difference to the upwind neighbour is
   // positive.
   // ------------------------------------------------------------------------
   always_comb begin
      if (s5_dxpos_ff == s5_dypos_ff) begin
         tmag_in = {1'b0, advx_m} + {1'b0, advy_m};
         tneg_in = s5_dxpos_ff;
      end else if (advx_m >= advy_m) begin
         tmag_in = {1'b0, advx_m - advy_m};
         tneg_in = s5_dxpos_ff;
      end else begin
         tmag_in = {1'b0, advy_m - advx_m};
         tneg_in = s5_dypos_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ld[6]) begin
         s6_center_ff <= s5_center_ff;
         s6_cneg_ff   <= s5_cneg_ff;
         s6_all4_ff   <= s5_all4_ff;
         s6_tmag_ff   <= tmag_in;
         s6_tneg_ff   <= tneg_in;
      end
   end

   // Both paths times the time step: products at stage 7, clamp at stage 8
   cts_mulq #(
      .MAG_W (cts_pkg::CAP_W),
      .F_W   (cts_pkg::TS_W)
   ) u_mulq_cond2 (
      .clock (clock),
      .ld    ('{prod: ld[7], cap: ld[8]}),
      .mag   (cond1_m),
      .fac   (ts_ff),
      .res   (cond2_m)
   );

   cts_mulq #(
      .MAG_W (cts_pkg::TMAG_W),
      .F_W   (cts_pkg::TS_W)
   ) u_mulq_advt (
      .clock (clock),
      .ld    ('{prod: ld[7], cap: ld[8]}),
      .mag   (s6_tmag_ff),
      .fac   (ts_ff),
      .res   (advt_m)
   );

   always_ff @(posedge clock) begin
      if (ld[7]) begin
         s7_center_ff <= s6_center_ff;
         s7_cneg_ff   <= s6_cneg_ff;
         s7_all4_ff   <= s6_all4_ff;
         s7_tneg_ff   <= s6_tneg_ff;
      end
      if (ld[8]) begin
         s8_center_ff <= s7_center_ff;
         s8_cneg_ff   <= s7_cneg_ff;
         s8_all4_ff   <= s7_all4_ff;
         s8_tneg_ff   <= s7_tneg_ff;
      end
   end

   // ------------------------------------------------------------------------
   // Result stage: centre plus conduction and, with all four neighbours, advection, saturated to Q16.16
   // ------------------------------------------------------------------------
   always_comb begin
      cond_s = s8_cneg_ff ? -$signed({1'b0, cond2_m}) : $signed({1'b0, cond2_m});
      if (!s8_all4_ff) begin
         adv_s = '0;
      end else begin
         adv_s = s8_tneg_ff ? -$signed({1'b0, advt_m}) : $signed({1'b0, advt_m});
      end
      total = cts_pkg::TOTAL_W'(s8_center_ff) + cts_pkg::TOTAL_W'(cond_s)
            + cts_pkg::TOTAL_W'(adv_s);
      if (!total[cts_pkg::TOTAL_W-1] && (|total[cts_pkg::TOTAL_W-2:31])) begin
         rsp_new_value_in = 32'sh7FFF_FFFF;
      end else if (total[cts_pkg::TOTAL_W-1] && !(&total[cts_pkg::TOTAL_W-2:31])) begin
         rsp_new_value_in = 32'sh8000_0000;
      end else begin
         rsp_new_value_in = total[cts_pkg::DATA_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (ld[NS]) begin
         rsp_new_value_ff <= rsp_new_value_in;
      end
   end

   assign rsp_new_value = rsp_new_value_ff;

`ifndef SYNTHESIS
   // Requests are refused only when every stage is occupied.
   a_stall_only_when_full: assert property (
      @(posedge clock) disable iff (reset)
      req_stall |-> (&v_ff)
   ) else $error("request refused while a pipeline stage is empty");

   // An accepted request occupies the first stage on the next cycle.
   a_accept_fills_stage1: assert property (
      @(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> v_ff[1]
   ) else $error("accepted request lost at the first stage");

   // A new result appears only from an occupied stage before it.
   a_result_from_pipeline: assert property (
      @(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(v_ff[NS-1])
   ) else $error("result presented without a request behind it");
`endif

endmodule
`default_nettype wire

// File: design/cts_mulq.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Fixed-point magnitude multiplier
// Two-stage unit computing floor(mag * fac / 2^16), clamped to the
// intermediate magnitude limit. The magnitude is split at bit 16 so that
// each partial product stays within one multiplier.
// ----------------------------------------------------------------------------
module cts_mulq #(
   parameter int MAG_W = 35,
   parameter int F_W   = 31
) (
   input  wire logic                     clock,
   input  wire cts_pkg::mulq_ld_type     ld,
   input  wire logic [MAG_W-1:0]         mag,
   input  wire logic [F_W-1:0]           fac,
   output logic [cts_pkg::CAP_W-1:0]     res
);

   localparam int HI_W  = MAG_W - cts_pkg::FRAC_W + F_W;
   localparam int LO_W  = cts_pkg::FRAC_W + F_W;
   localparam int ACC_W = HI_W + 1;
   localparam int CMP_W = (ACC_W > cts_pkg::CAP_W) ? ACC_W : cts_pkg::CAP_W;

   logic [HI_W-1:0]           hi_ff, hi_in;
   logic [LO_W-1:0]           lo_ff, lo_in;
   logic [ACC_W-1:0]          acc;
   logic [CMP_W-1:0]          acc_ext;
   logic [cts_pkg::CAP_W-1:0] res_ff, res_in;

   always_comb begin
      hi_in = {{F_W{1'b0}}, mag[MAG_W-1:cts_pkg::FRAC_W]}
            * {{(MAG_W-cts_pkg::FRAC_W){1'b0}}, fac};
      lo_in = {{F_W{1'b0}}, mag[cts_pkg::FRAC_W-1:0]}
            * {{cts_pkg::FRAC_W{1'b0}}, fac};
   end

   always_comb begin
      acc     = {1'b0, hi_ff} + ACC_W'(lo_ff[LO_W-1:cts_pkg::FRAC_W]);
      acc_ext = CMP_W'(acc);
      if (acc_ext > CMP_W'(cts_pkg::ICAP)) begin
         res_in = cts_pkg::ICAP;
      end else begin
         res_in = acc_ext[cts_pkg::CAP_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (ld.prod) begin
         hi_ff <= hi_in;
         lo_ff <= lo_in;
      end
      if (ld.cap) begin
         res_ff <= res_in;
      end
   end

   assign res = res_ff;

endmodule
`default_nettype wire

// File: tb/cloud_temperature_stencil_cell_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cloud temperature stencil cell testbench
// Streams stencil requests through the cell under random idling on both sides
// and across several register settings. Each accepted request is run through
// a fixed-point predictor of the cell. Every returned temperature must match
// the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module cloud_temperature_stencil_cell_top_test;

   import cts_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;
   localparam logic signed [DATA_W-1:0] TEMP_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [DATA_W-1:0] TEMP_MIN = 32'sh8000_0000;
   localparam logic signed [DATA_W-1:0] ONE_Q16  = 32'sh0001_0000;
   localparam logic [CSR_DATA_W-1:0]    REG_MAX  = 31'h7FFF_FFFF;

   typedef struct packed {
      logic signed [DATA_W-1:0] center;
      logic signed [DATA_W-1:0] north;
      logic signed [DATA_W-1:0] west;
      logic signed [DATA_W-1:0] east;
      logic signed [DATA_W-1:0] south;
      logic signed [DATA_W-1:0] wind_x;
      logic signed [DATA_W-1:0] wind_y;
   } stencil_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   stencil_t req_cell = '0;
   logic req_valid = 1'b0;
   logic req_stall;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [DATA_W-1:0] rsp_new_value;
   logic csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // Predictor copy of the registers
   logic [TS_W-1:0]   step_q = TS_RESET;
   logic [COND_W-1:0] cond_q = COND_RESET;
   logic [INVL_W-1:0] invl_q = INVL_RESET;

   stencil_t cell_queue[$];
   logic [DATA_W-1:0] expected_temps[$];
   logic [DATA_W-1:0] oldest_temp;
   logic req_fire = 1'b0;
   logic hold_sender = 1'b0;
   logic idling_on = 1'b1;
   int send_gap = 0;
   int stall_left = 0;
   int failures = 0;

   cloud_temperature_stencil_cell_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_center_value (req_cell.center),
      .req_north_value  (req_cell.north),
      .req_west_value   (req_cell.west),
      .req_east_value   (req_cell.east),
      .req_south_value  (req_cell.south),
      .req_wind_x_speed (req_cell.wind_x),
      .req_wind_y_speed (req_cell.wind_y),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_new_value    (rsp_new_value),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always #2 clock = ~clock;

   initial begin
      #2_000_000;
      $display("FAIL cloud_temperature_stencil_cell_top");
      $finish;
   end

   function automatic longint magnitude(longint v);
      return (v < 0) ? -v : v;
   endfunction

   // Q16.16 product of a magnitude and a factor, truncated and clamped.
   function automatic longint scale_q16(longint mag, longint factor);
      logic [127:0] p;
      p = (128'(mag) * 128'(factor)) >> FRAC_W;
      if (p > 128'(ICAP)) p = 128'(ICAP);
      return longint'(p[63:0]);
   endfunction

   function automatic longint drift_term(longint diff, longint wind);
      longint m;
      m = scale_q16(magnitude(diff) * longint'(invl_q), magnitude(wind));
      return (diff > 0) ? -m : m;
   endfunction

   function automatic logic [DATA_W-1:0] next_temperature(stencil_t s);
      longint c, sum, cond, adv, drift, m, res, up_x, up_y;
      longint nb[4];
      int count;
      c = s.center;
      nb[0] = s.north;
      nb[1] = s.west;
      nb[2] = s.east;
      nb[3] = s.south;
      sum = 0;
      count = 0;
      cond = 0;
      adv = 0;
      for (int k = 0; k < 4; k++) begin
         if (nb[k] != 0) begin
            sum += c - nb[k];
            count++;
         end
      end
      if (count != 0) begin
         m = scale_q16(scale_q16(magnitude(sum) / count, longint'(cond_q)), longint'(step_q));
         cond = (sum > 0) ? -m : m;
      end
      // Advection only applies to interior cells with all four neighbours.
      if (count == 4) begin
         up_x = (longint'(s.wind_x) > 0) ? nb[0] : nb[3];
         up_y = (longint'(s.wind_y) > 0) ? nb[1] : nb[2];
         drift = drift_term(c - up_x, s.wind_x) + drift_term(c - up_y, s.wind_y);
         m = scale_q16(magnitude(drift), longint'(step_q));
         adv = (drift < 0) ? -m : m;
      end
      res = c + cond + adv;
      if (res > longint'(TEMP_MAX)) res = TEMP_MAX;
      if (res < longint'(TEMP_MIN)) res = TEMP_MIN;
      return res[DATA_W-1:0];
   endfunction

   task automatic note_mismatch(string what, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
      if (failures < 10)
         $display("%s: expected %h, got %h at %0t", what, want, got, $realtime);
      failures++;
   endtask

   // Request side: new requests and payloads change on the falling edge.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (send_gap != 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (!hold_sender && cell_queue.size() != 0) begin
            req_cell <= cell_queue.pop_front();
            req_valid <= 1'b1;
            if (idling_on && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 15);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (!reset && idling_on && stall_left == 0 && $urandom_range(0, 5) == 0)
         stall_left = $urandom_range(1, 15);
      if (stall_left != 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      req_fire <= !reset && req_valid && !req_stall;
      if (!reset && req_valid && !req_stall)
         expected_temps.push_back(next_temperature(req_cell));
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_temps.size() == 0) begin
            note_mismatch("result with no request outstanding", 'x, rsp_new_value);
         end else begin
            oldest_temp = expected_temps.pop_front();
            if (rsp_new_value !== oldest_temp)
               note_mismatch("new_value mismatch", oldest_temp, rsp_new_value);
         end
      end
   end

   task automatic push_cell(logic signed [DATA_W-1:0] c, n, w, e, s, wx, wy);
      stencil_t entry;
      entry.center = c;
      entry.north  = n;
      entry.west   = w;
      entry.east   = e;
      entry.south  = s;
      entry.wind_x = wx;
      entry.wind_y = wy;
      cell_queue.push_back(entry);
   endtask

   task automatic push_directed();
      push_cell(0, 0, 0, 0, 0, 0, 0);
      push_cell(TEMP_MAX, 0, 0, 0, 0, TEMP_MIN, TEMP_MIN);
      push_cell(5 * ONE_Q16, 3 * ONE_Q16, 0, 0, 0, ONE_Q16, ONE_Q16);
      push_cell(-2 * ONE_Q16, 0, 0, 7 * ONE_Q16, -9 * ONE_Q16, -ONE_Q16, ONE_Q16);
      push_cell(ONE_Q16, 4 * ONE_Q16, -ONE_Q16, 2, 0, TEMP_MAX, TEMP_MAX);
      push_cell(20 * ONE_Q16, 21 * ONE_Q16, 19 * ONE_Q16, 18 * ONE_Q16, 25 * ONE_Q16, 0, 0);
      push_cell(20 * ONE_Q16, 30 * ONE_Q16, 10 * ONE_Q16, 18 * ONE_Q16, 25 * ONE_Q16,
                3 * ONE_Q16, 2 * ONE_Q16);
      push_cell(20 * ONE_Q16, 30 * ONE_Q16, 10 * ONE_Q16, 18 * ONE_Q16, 25 * ONE_Q16,
                -3 * ONE_Q16, -2 * ONE_Q16);
      push_cell(TEMP_MAX, TEMP_MIN, TEMP_MIN, TEMP_MIN, TEMP_MIN, TEMP_MIN, TEMP_MIN);
      push_cell(TEMP_MIN, TEMP_MAX, TEMP_MAX, TEMP_MAX, TEMP_MAX, TEMP_MAX, TEMP_MAX);
      push_cell(TEMP_MIN, 1, 1, 1, 1, TEMP_MAX, TEMP_MIN);
      push_cell(-ONE_Q16, TEMP_MAX, -1, TEMP_MIN, 1, 1, TEMP_MIN);
   endtask

   function automatic logic signed [DATA_W-1:0] pick_temp();
      case ($urandom_range(0, 9))
         0: return TEMP_MAX;
         1: return TEMP_MIN;
         2, 3: return $urandom;
         default: return 32'($urandom_range(0, 13_107_200)) - 32'd6_553_600;
      endcase
   endfunction

   function automatic logic signed [DATA_W-1:0] pick_wind();
      case ($urandom_range(0, 9))
         0: return 0;
         1: return $urandom_range(0, 1) ? TEMP_MAX : TEMP_MIN;
         2, 3: return $urandom;
         default: return 32'($urandom_range(0, 2_621_440)) - 32'd1_310_720;
      endcase
   endfunction

   // Mostly interior cells with realistic gradients; the rest are edge cells
   // with absent neighbours, or arbitrary values.
   task automatic push_random(int count);
      logic signed [DATA_W-1:0] c;
      logic signed [DATA_W-1:0] nb[4];
      int mode;
      repeat (count) begin
         mode = $urandom_range(0, 9);
         c = pick_temp();
         for (int k = 0; k < 4; k++) begin
            if (mode < 3 && $urandom_range(0, 1) == 0)
               nb[k] = 0;
            else if (mode == 9 || $urandom_range(0, 3) == 0)
               nb[k] = pick_temp();
            else
               nb[k] = c + 32'($urandom_range(0, 1_048_576)) - 32'd524_288;
            if (mode >= 3 && nb[k] == 0) nb[k] = 1;
         end
         push_cell(c, nb[0], nb[1], nb[2], nb[3], pick_wind(), pick_wind());
      end
   endtask

   task automatic wait_idle();
      while (cell_queue.size() != 0 || req_valid || expected_temps.size() != 0)
         @(posedge clock);
      repeat (N_STAGES + 4) @(posedge clock);
   endtask

   task automatic write_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_TIME_STEP:    step_q = data[TS_W-1:0];
         CSR_CONDUCTIVITY: cond_q = data[COND_W-1:0];
         CSR_INV_CELL_LEN: invl_q = data[INVL_W-1:0];
         default: ;
      endcase
   endtask

   task automatic apply_settings(logic [CSR_DATA_W-1:0] step, cond, invl);
      write_register(CSR_TIME_STEP, step);
      write_register(CSR_CONDUCTIVITY, cond);
      write_register(CSR_INV_CELL_LEN, invl);
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset values first.
      push_directed();
      push_random(120);
      wait_idle();

      apply_settings(REG_MAX, REG_MAX, 31'd2047);
      write_register(CSR_UNUSED, 31'($urandom));
      push_directed();
      push_random(150);
      wait_idle();

      apply_settings(31'd0, 31'd0, 31'd0);
      push_random(120);
      wait_idle();

      apply_settings(31'(ONE_Q16), 31'(ONE_Q16), 31'd1);
      push_random(150);
      // Hold new requests back half way until the pipeline has emptied.
      while (cell_queue.size() > 75) @(posedge clock);
      hold_sender = 1'b1;
      while (req_valid || expected_temps.size() != 0) @(posedge clock);
      hold_sender = 1'b0;
      wait_idle();

      apply_settings(31'($urandom), 31'($urandom), 31'($urandom_range(0, 2047)));
      push_random(150);
      wait_idle();

      apply_settings(31'($urandom_range(0, 131_072)), 31'($urandom_range(0, 131_072)),
                     31'($urandom_range(1, 1024)));
      push_random(110);
      wait_idle();
      idling_on = 1'b0;
      push_random(150);
      while (cell_queue.size() != 0 || req_valid || expected_temps.size() != 0)
         @(posedge clock);
      repeat (N_STAGES * 4) @(posedge clock);

      if (expected_temps.size() != 0) begin
         $display("%0d results never returned", expected_temps.size());
         failures++;
      end
      if (failures == 0)
         $display("PASS cloud_temperature_stencil_cell_top");
      else
         $display("FAIL cloud_temperature_stencil_cell_top");
      $finish;
   end

endmodule

// File: sim.f
design/cts_pkg.sv
design/cts_mulq.sv
design/cloud_temperature_stencil_cell_top.sv
tb/cloud_temperature_stencil_cell_top_test.sv
